// ===== hdl/mcee_pkg.sv =====
`default_nettype none

package mcee_pkg;

    localparam int unsigned CFG_COUNT = 5;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned PAT_W     = 6;
    localparam int unsigned LEN_W     = 3;

    typedef logic [2:0]        t_cfg_addr;
    typedef logic [TICK_W-1:0] t_ticks;
    typedef logic [CHAR_W-1:0] t_char;

    localparam t_cfg_addr CFG_DOT_ON    = 3'd0;
    localparam t_cfg_addr CFG_DASH_ON   = 3'd1;
    localparam t_cfg_addr CFG_ELEM_GAP  = 3'd2;
    localparam t_cfg_addr CFG_CHAR_GAP  = 3'd3;
    localparam t_cfg_addr CFG_WORD_GAP  = 3'd4;

    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_PERIOD = 8'h2E;
    localparam t_char CH_R      = 8'h52;
    localparam t_char CASE_MASK = 8'hDF;

    // element read request towards the register store
    typedef struct packed {
        logic      en;
        logic      on_zero;
        t_cfg_addr on_addr;
        t_cfg_addr off_addr;
    } t_rd_req;

    typedef struct packed {
        logic             known;
        logic [PAT_W-1:0] bits;   // first element in the top bit, 1 = dash
        logic [LEN_W-1:0] len;
    } t_sym;

    function automatic t_ticks cfg_reset_value(input t_cfg_addr a);
        t_ticks v;
        case (a)
            CFG_DOT_ON:   v = 32'd31000000;
            CFG_DASH_ON:  v = 32'd124000000;
            CFG_ELEM_GAP: v = 32'd40300000;
            CFG_CHAR_GAP: v = 32'd130200000;
            CFG_WORD_GAP: v = 32'd322400000;
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic t_sym sym_lookup(input t_char c);
        logic [7:0]       b;
        logic [LEN_W-1:0] n;
        t_sym             s;
        b = 8'h00;
        n = 3'd0;
        case (c)
            8'h41: begin b = 8'h40; n = 3'd2; end
            8'h42: begin b = 8'h80; n = 3'd4; end
            8'h43: begin b = 8'hA0; n = 3'd4; end
            8'h44: begin b = 8'h80; n = 3'd3; end
            8'h45: begin b = 8'h00; n = 3'd1; end
            8'h46: begin b = 8'h20; n = 3'd4; end
            8'h47: begin b = 8'hC0; n = 3'd3; end
            8'h48: begin b = 8'h00; n = 3'd4; end
            8'h49: begin b = 8'h00; n = 3'd2; end
            8'h4A: begin b = 8'h70; n = 3'd4; end
            8'h4B: begin b = 8'hA0; n = 3'd3; end
            8'h4C: begin b = 8'h40; n = 3'd4; end
            8'h4D: begin b = 8'hC0; n = 3'd2; end
            8'h4E: begin b = 8'h80; n = 3'd2; end
            8'h4F: begin b = 8'hE0; n = 3'd3; end
            8'h50: begin b = 8'h60; n = 3'd4; end
            8'h51: begin b = 8'hD0; n = 3'd4; end
            8'h52: begin b = 8'h40; n = 3'd3; end
            8'h53: begin b = 8'h00; n = 3'd3; end
            8'h54: begin b = 8'h80; n = 3'd1; end
            8'h55: begin b = 8'h20; n = 3'd3; end
            8'h56: begin b = 8'h10; n = 3'd4; end
            8'h57: begin b = 8'h60; n = 3'd3; end
            8'h58: begin b = 8'h90; n = 3'd4; end
            8'h59: begin b = 8'hB0; n = 3'd4; end
            8'h5A: begin b = 8'hC0; n = 3'd4; end
            8'h30: begin b = 8'hF8; n = 3'd5; end
            8'h31: begin b = 8'h78; n = 3'd5; end
            8'h32: begin b = 8'h38; n = 3'd5; end
            8'h33: begin b = 8'h18; n = 3'd5; end
            8'h34: begin b = 8'h08; n = 3'd5; end
            8'h35: begin b = 8'h00; n = 3'd5; end
            8'h36: begin b = 8'h80; n = 3'd5; end
            8'h37: begin b = 8'hC0; n = 3'd5; end
            8'h38: begin b = 8'hE0; n = 3'd5; end
            8'h39: begin b = 8'hF0; n = 3'd5; end
            8'h2E: begin b = 8'h54; n = 3'd6; end
            8'h2C: begin b = 8'hCC; n = 3'd6; end
            8'h3F: begin b = 8'h30; n = 3'd6; end
            8'h2D: begin b = 8'h88; n = 3'd5; end
            8'h40: begin b = 8'h68; n = 3'd6; end
            8'h5F: begin b = 8'h34; n = 3'd6; end
            8'h2B: begin b = 8'h50; n = 3'd5; end
            8'h3B: begin b = 8'hA8; n = 3'd6; end
            8'h26: begin b = 8'h40; n = 3'd5; end
            8'h2F: begin b = 8'h90; n = 3'd5; end
            8'h28: begin b = 8'hB0; n = 3'd5; end
            8'h29: begin b = 8'hB4; n = 3'd6; end
            default: begin b = 8'h00; n = 3'd0; end
        endcase
        s.known = (n != 3'd0);
        s.bits  = b[7:8-PAT_W];
        s.len   = n;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mcee_cfg_mem.sv =====
`default_nettype none

module mcee_cfg_mem (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire mcee_pkg::t_cfg_addr i_wr_addr,
    input  wire mcee_pkg::t_ticks   i_wr_data,
    input  wire mcee_pkg::t_rd_req  i_rd,
    output logic                    o_rd_valid,
    output mcee_pkg::t_ticks        o_on,
    output mcee_pkg::t_ticks        o_off
);
    import mcee_pkg::*;

    t_ticks               r_mem [CFG_COUNT];
    logic [CFG_COUNT-1:0] r_vld;
    t_ticks               r_on;
    t_ticks               r_off;
    logic                 r_rd_valid;
    t_ticks               n_on;
    t_ticks               n_off;

    // unwritten entries read as their reset value
    always_comb begin
        n_on  = r_vld[i_rd.on_addr]  ? r_mem[i_rd.on_addr]  : cfg_reset_value(i_rd.on_addr);
        n_off = r_vld[i_rd.off_addr] ? r_mem[i_rd.off_addr] : cfg_reset_value(i_rd.off_addr);
        if (i_rd.on_zero) begin
            n_on = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd.en;
            if (i_wr_en && (i_wr_addr < t_cfg_addr'(CFG_COUNT))) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr < t_cfg_addr'(CFG_COUNT))) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd.en) begin
            r_on  <= n_on;
            r_off <= n_off;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_on       = r_on;
    assign o_off      = r_off;

endmodule

`default_nettype wire

// ===== hdl/morse_code_element_encoder_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] character, tuser string_start
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[31:0] on, [63:32] off, tlast last
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data (32 bit)
//
// An item is taken while idle, then one element per cycle while the output is free:
// len + 1 elements per symbol (up to 7), one for a space, none for an unknown character.
// Element ticks are read from the register store, one read per element.
// Reset clears the sequencer, previous character and register-store valid bits.
// A stalled output holds its element; the sequencer waits on it.

module morse_code_element_encoder_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] character
    input  wire logic                 s_axis_tuser,   // [0] string_start
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [63:0]               m_axis_tdata,   // [31:0] on_ticks, [63:32] off_ticks
    output logic                      m_axis_tlast,   // last
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire mcee_pkg::t_cfg_addr  i_cfg_index,
    input  wire mcee_pkg::t_ticks     i_cfg_data
);
    import mcee_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_char            r_prev;
    logic [PAT_W-1:0] r_bits;
    logic [LEN_W-1:0] r_cnt;
    logic             r_space;
    logic             r_ovalid;
    logic             r_olast;

    t_char   n_prev_eff;
    t_char   n_ch;
    t_sym    n_sym;
    logic    in_acc;
    logic    out_free;
    logic    issue;
    logic    issue_last;
    t_rd_req rd;
    logic    rd_valid;
    t_ticks  rd_on;
    t_ticks  rd_off;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign issue         = (r_state == S_EMIT) && out_free;
    assign issue_last    = r_space || (r_cnt == '0);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_prev_eff = s_axis_tuser ? '0 : r_prev;
        n_ch       = s_axis_tdata;
        if ((n_ch == CH_PERIOD) && (n_prev_eff inside {[8'h30:8'h39]})) begin
            n_ch = CH_R;
        end
        if (n_ch inside {[8'h61:8'h7A]}) begin
            n_ch = n_ch & CASE_MASK;
        end
        n_sym = sym_lookup(n_ch);
    end

    always_comb begin
        rd.en       = issue;
        rd.on_zero  = issue_last;
        rd.on_addr  = r_bits[PAT_W-1] ? CFG_DASH_ON : CFG_DOT_ON;
        rd.off_addr = r_space ? CFG_WORD_GAP : ((r_cnt == '0) ? CFG_CHAR_GAP : CFG_ELEM_GAP);
    end

    mcee_cfg_mem u_cfg_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_addr  (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .i_rd       (rd),
        .o_rd_valid (rd_valid),
        .o_on       (rd_on),
        .o_off      (rd_off)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_bits   <= '0;
            r_cnt    <= '0;
            r_space  <= 1'b0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (issue) begin
                r_ovalid <= 1'b1;
                r_olast  <= issue_last;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tdata == CH_SPACE) begin
                            r_prev  <= n_prev_eff;
                            r_space <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_prev  <= n_ch;
                            r_space <= 1'b0;
                            r_bits  <= n_sym.bits;
                            r_cnt   <= n_sym.len;
                            if (n_sym.known) begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        if (issue_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt  <= r_cnt - 1'b1;
                            r_bits <= {r_bits[PAT_W-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {rd_off, rd_on};

    a_last_is_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[31:0] == '0))
        else $error("final element carries an on time");

    a_mid_elem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (r_state == S_EMIT))
        else $error("symbol left unfinished");

    a_fresh_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_valid |-> m_axis_tvalid)
        else $error("element read without output");

endmodule

`default_nettype wire
